// File: rtl/pthc_pkg.sv
`default_nettype none
package pthc_pkg;

  localparam int TFW = 20;  // fine temperature
  localparam int TCW = 15;  // temperature in centi degC
  localparam int PW  = 25;  // pressure q8
  localparam int HW  = 17;  // humidity q10
  localparam int NW  = 70;  // scaled dividend magnitude
  localparam int DMW = 34;  // divisor magnitude
  localparam int QW  = 36;  // quotient bits before saturation
  localparam int QSW = 37;  // signed, saturated quotient
  localparam int CIW = 3;   // register index width

  typedef enum logic [CIW-1:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUM      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coeffs_t;

  typedef struct packed {
    logic signed [TCW-1:0] temp;
    logic signed [TFW-1:0] tf;
    logic        [15:0]    adc_hum;
  } side_t;

  typedef struct packed {
    logic [NW-1:0]  num;
    logic [DMW-1:0] dmag;
    logic           neg;
    logic           zero;
    side_t          side;
  } div_in_t;

  typedef struct packed {
    logic signed [QSW-1:0] q;
    logic                  zero;
    side_t                 side;
  } div_out_t;

  typedef struct packed {
    logic signed [TCW-1:0] temp;
    logic signed [TFW-1:0] tf;
    logic        [PW-1:0]  press;
    logic                  pvalid;
    logic        [HW-1:0]  hum;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/pthc_front.sv
`default_nettype none
module pthc_front
  import pthc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [19:0] adc_temp,
  input  wire logic [19:0] adc_press,
  input  wire logic [15:0] adc_hum,
  input  wire coeffs_t     c,
  output logic             out_valid,
  output div_in_t          out
);

  logic [9:0] vld;

  // stage 1
  logic signed [20:0] a_c;
  logic signed [36:0] s1_at2;
  logic signed [41:0] s1_asq;
  logic        [19:0] s1_adc_p;
  logic        [15:0] s1_adc_h;
  // stage 2
  logic signed [36:0] s2_at2;
  logic signed [57:0] s2_n3;
  logic        [19:0] s2_adc_p;
  logic        [15:0] s2_adc_h;
  // stage 3
  logic signed [58:0] num_c;
  logic signed [58:0] num_r;
  logic signed [24:0] tq_c;
  logic signed [TFW-1:0] s3_tf;
  logic        [19:0] s3_adc_p;
  logic        [15:0] s3_adc_h;
  // stage 4
  logic signed [20:0] v1_c;
  logic signed [23:0] t5_c;
  logic signed [15:0] tc_c;
  logic signed [41:0] s4_v1sq;
  logic signed [36:0] s4_v1p5;
  logic signed [36:0] s4_v1p2;
  logic signed [TCW-1:0] s4_temp;
  logic signed [TFW-1:0] s4_tf;
  logic        [19:0] s4_adc_p;
  logic        [15:0] s4_adc_h;
  // stage 5
  logic signed [57:0] s5_v2a;
  logic signed [57:0] s5_v1a;
  logic signed [36:0] s5_v1p5;
  logic signed [36:0] s5_v1p2;
  side_t              s5_side;
  logic        [19:0] s5_adc_p;
  // stage 6
  logic signed [59:0] s6_v2;
  logic signed [51:0] s6_u;
  side_t              s6_side;
  logic        [19:0] s6_adc_p;
  // stage 7
  logic        [20:0] dm_c;
  logic signed [34:0] uh_c;
  logic signed [51:0] s7_muh;
  logic        [32:0] s7_mul;
  logic signed [56:0] s7_d;
  side_t              s7_side;
  // stage 8
  logic signed [51:0] den_c;
  logic signed [33:0] s8_den;
  logic signed [56:0] s8_d;
  side_t              s8_side;
  // stage 9
  logic        [55:0] s9_dmag;
  logic [DMW-1:0]     s9_denmag;
  logic               s9_neg;
  logic               s9_zero;
  side_t              s9_side;

  assign a_c   = $signed({1'b0, adc_temp}) - $signed({1'b0, c.t1, 4'h0});
  assign num_c = 59'($signed({s2_at2, 20'h0})) + 59'(s2_n3);
  // truncate toward zero
  assign num_r = num_c + (num_c[58] ? 59'sh3_FFFF_FFFF : 59'sd0);
  assign tq_c  = num_r[58:34];
  assign v1_c  = 21'(s3_tf) - 21'sd128000;
  assign t5_c  = 24'(s3_tf) * 24'sd5 + 24'sd128;
  assign tc_c  = t5_c[23:8];
  assign dm_c  = 21'h10_0000 - {1'b0, s6_adc_p};
  assign uh_c  = s6_u[51:17];
  assign den_c = s7_muh + 52'(s7_mul >> 17);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_at2   <= 37'(a_c) * 37'(c.t2);
      s1_asq   <= 42'(a_c) * 42'(a_c);
      s1_adc_p <= adc_press;
      s1_adc_h <= adc_hum;

      s2_at2   <= s1_at2;
      s2_n3    <= 58'(s1_asq) * 58'(c.t3);
      s2_adc_p <= s1_adc_p;
      s2_adc_h <= s1_adc_h;

      if (tq_c > 25'sd524287) begin
        s3_tf <= 20'sd524287;
      end else if (tq_c < -25'sd524288) begin
        s3_tf <= -20'sd524288;
      end else begin
        s3_tf <= tq_c[19:0];
      end
      s3_adc_p <= s2_adc_p;
      s3_adc_h <= s2_adc_h;

      s4_v1sq <= 42'(v1_c) * 42'(v1_c);
      s4_v1p5 <= 37'(v1_c) * 37'(c.p5);
      s4_v1p2 <= 37'(v1_c) * 37'(c.p2);
      if (tc_c > 16'sd8500) begin
        s4_temp <= 15'sd8500;
      end else if (tc_c < -16'sd4000) begin
        s4_temp <= -15'sd4000;
      end else begin
        s4_temp <= tc_c[14:0];
      end
      s4_tf    <= s3_tf;
      s4_adc_p <= s3_adc_p;
      s4_adc_h <= s3_adc_h;

      s5_v2a          <= 58'(s4_v1sq) * 58'(c.p6);
      s5_v1a          <= 58'(s4_v1sq) * 58'(c.p3);
      s5_v1p5         <= s4_v1p5;
      s5_v1p2         <= s4_v1p2;
      s5_side.temp    <= s4_temp;
      s5_side.tf      <= s4_tf;
      s5_side.adc_hum <= s4_adc_h;
      s5_adc_p        <= s4_adc_p;

      s6_v2 <= 60'(s5_v2a) + 60'($signed({s5_v1p5, 17'h0}))
             + 60'($signed({c.p4, 35'h0}));
      s6_u  <= 52'(s5_v1a >>> 8) + 52'($signed({s5_v1p2, 12'h0}))
             + 52'sh8000_0000_0000;
      s6_side  <= s5_side;
      s6_adc_p <= s5_adc_p;

      s7_muh  <= 52'(uh_c) * 52'($signed({1'b0, c.p1}));
      s7_mul  <= 33'(s6_u[16:0]) * 33'(c.p1);
      s7_d    <= 57'($signed({1'b0, dm_c, 31'h0})) - 57'(s6_v2);
      s7_side <= s6_side;

      s8_den  <= den_c[49:16];
      s8_d    <= s7_d;
      s8_side <= s7_side;

      s9_dmag   <= s8_d[56] ? 56'(-s8_d) : 56'(s8_d);
      s9_denmag <= s8_den[33] ? DMW'(-s8_den) : DMW'(s8_den);
      s9_neg    <= s8_d[56] ^ s8_den[33];
      s9_zero   <= (s8_den == 34'sd0);
      s9_side   <= s8_side;

      out.num  <= NW'(s9_dmag) * NW'(12'd3125);
      out.dmag <= s9_denmag;
      out.neg  <= s9_neg;
      out.zero <= s9_zero;
      out.side <= s9_side;
    end
  end

  assign out_valid = vld[9];

endmodule
`default_nettype wire

// File: rtl/pthc_div.sv
`default_nettype none
module pthc_div
  import pthc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire div_in_t in,
  output logic         out_valid,
  output div_out_t     out
);

  typedef struct packed {
    logic [NW-1:0]  rem;
    logic [DMW-1:0] dmag;
    logic [QW-1:0]  q;
    logic           ovf;
    logic           neg;
    logic           zero;
    side_t          side;
  } dstage_t;

  logic [QW:0] vld;
  dstage_t     st [QW+1];
  logic        ovf_c;
  logic [QW-1:0] mag_c;

  // quotient would reach 2^QW: saturate
  assign ovf_c = in.num[NW-1:QW] >= in.dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= in.num;
      st[0].dmag <= in.dmag;
      st[0].q    <= '0;
      st[0].ovf  <= ovf_c;
      st[0].neg  <= in.neg;
      st[0].zero <= in.zero;
      st[0].side <= in.side;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int B = QW - 1 - i;
    logic [NW-1:0] dsh;
    logic          ge;
    dstage_t       nxt;

    always_comb begin
      dsh        = NW'(st[i].dmag) << B;
      ge         = st[i].rem >= dsh;
      nxt        = st[i];
      nxt.rem    = ge ? st[i].rem - dsh : st[i].rem;
      nxt.q[B]   = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign mag_c = (st[QW].ovf || st[QW].q[QW-1]) ? {1'b1, {(QW-1){1'b0}}} : st[QW].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.q    <= st[QW].neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      out.zero <= st[QW].zero;
      out.side <= st[QW].side;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pthc_back.sv
`default_nettype none
module pthc_back
  import pthc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire div_out_t in,
  input  wire coeffs_t  c,
  output logic          out_valid,
  output res_t          out
);

  logic [8:0] vld;

  // pressure correction
  logic signed [47:0] p1_sq;
  logic signed [52:0] p1_c2m;
  logic signed [QSW-1:0] p1_q;
  logic               p1_zero;
  logic signed [63:0] p2_c1m;
  logic signed [52:0] p2_c2m;
  logic signed [QSW-1:0] p2_q;
  logic               p2_zero;
  logic signed [39:0] p3_sum;
  logic               p3_zero;
  logic signed [39:0] p4_ps;
  logic               p4_zero;
  logic [PW-1:0]      p5_press;
  logic               p5_pvalid;
  logic [PW-1:0]      pr_press [3];
  logic               pr_pvalid [3];

  // humidity
  logic signed [20:0] hv_c;
  logic signed [32:0] h1_m5;
  logic signed [28:0] h1_m6;
  logic signed [29:0] h1_m3;
  logic        [15:0] h1_adc;
  logic signed [34:0] ha_c;
  logic signed [19:0] h2_ha;
  logic signed [18:0] h2_x;
  logic signed [19:0] h2_y;
  logic signed [38:0] h3_hb0;
  logic signed [19:0] h3_ha;
  logic signed [29:0] hb0s_c;
  logic signed [45:0] h4_hb1;
  logic signed [19:0] h4_ha;
  logic signed [45:0] hb_c;
  logic signed [26:0] h5_hb;
  logic signed [19:0] h5_ha;
  logic signed [46:0] h6_hvp;
  logic signed [27:0] s_c;
  logic signed [55:0] h7_sq;
  logic signed [46:0] h7_hvp;
  logic signed [57:0] h8_t;
  logic signed [46:0] h8_hvp;
  logic signed [57:0] hvf_c;
  logic        [28:0] hcl_c;

  side_t sd [8];

  assign hv_c   = 21'(in.side.tf) - 21'sd76800;
  assign ha_c   = $signed({5'b0, h1_adc, 14'h0}) - 35'($signed({c.h4, 20'h0}))
                - 35'(h1_m5) + 35'sd16384;
  assign hb0s_c = 30'(h3_hb0 >>> 10) + 30'sd2097152;
  assign hb_c   = h4_hb1 + 46'sd8192;
  assign s_c    = h6_hvp[42:15];
  assign hvf_c  = 58'(h8_hvp) - (h8_t >>> 4);
  assign hcl_c  = hvf_c[57] ? 29'd0 :
                  (hvf_c > 58'sd419430400) ? 29'd419430400 : hvf_c[28:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      p1_sq   <= 48'($signed(in.q[QSW-1:13])) * 48'($signed(in.q[QSW-1:13]));
      p1_c2m  <= 53'(in.q) * 53'(c.p8);
      p1_q    <= in.q;
      p1_zero <= in.zero;
      h1_m5   <= 33'(hv_c) * 33'(c.h5);
      h1_m6   <= 29'(hv_c) * 29'(c.h6);
      h1_m3   <= 30'(hv_c) * 30'($signed({1'b0, c.h3}));
      h1_adc  <= in.side.adc_hum;
      sd[0]   <= in.side;

      // stage 2
      p2_c1m  <= 64'(p1_sq) * 64'(c.p9);
      p2_c2m  <= p1_c2m;
      p2_q    <= p1_q;
      p2_zero <= p1_zero;
      h2_ha   <= ha_c[34:15];
      h2_x    <= h1_m6[28:10];
      h2_y    <= 20'($signed(h1_m3[29:11])) + 20'sd32768;
      sd[1]   <= sd[0];

      // stage 3
      p3_sum  <= 40'(p2_q) + 40'(p2_c1m >>> 25) + 40'(p2_c2m >>> 19);
      p3_zero <= p2_zero;
      h3_hb0  <= 39'(h2_x) * 39'(h2_y);
      h3_ha   <= h2_ha;
      sd[2]   <= sd[1];

      // stage 4
      p4_ps   <= (p3_sum >>> 8) + 40'($signed({c.p7, 4'h0}));
      p4_zero <= p3_zero;
      h4_hb1  <= 46'(hb0s_c) * 46'(c.h2);
      h4_ha   <= h3_ha;
      sd[3]   <= sd[2];

      // stage 5: pressure done, zero divisor forces 0
      if (p4_zero || p4_ps[39]) begin
        p5_press <= '0;
      end else if (p4_ps > 40'sd33554431) begin
        p5_press <= {PW{1'b1}};
      end else begin
        p5_press <= p4_ps[PW-1:0];
      end
      p5_pvalid <= !p4_zero;
      h5_hb     <= 27'(hb_c >>> 14);
      h5_ha     <= h4_ha;
      sd[4]     <= sd[3];

      // stage 6
      h6_hvp       <= 47'(h5_ha) * 47'(h5_hb);
      pr_press[0]  <= p5_press;
      pr_pvalid[0] <= p5_pvalid;
      sd[5]        <= sd[4];

      // stage 7
      h7_sq        <= 56'(s_c) * 56'(s_c);
      h7_hvp       <= h6_hvp;
      pr_press[1]  <= pr_press[0];
      pr_pvalid[1] <= pr_pvalid[0];
      sd[6]        <= sd[5];

      // stage 8
      h8_t         <= 58'(h7_sq >>> 7) * 58'($signed({1'b0, c.h1}));
      h8_hvp       <= h7_hvp;
      pr_press[2]  <= pr_press[1];
      pr_pvalid[2] <= pr_pvalid[1];
      sd[7]        <= sd[6];

      // stage 9: output register
      out.temp   <= sd[7].temp;
      out.tf     <= sd[7].tf;
      out.press  <= pr_press[2];
      out.pvalid <= pr_pvalid[2];
      out.hum    <= hcl_c[28:12];
    end
  end

  assign out_valid = vld[8];

endmodule
`default_nettype wire

// File: rtl/pth_sensor_compensation_top.sv
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: adc_temp, adc_press, adc_hum
// m_axis    out  m_axis_tvalid/tready    tdata: temp_centi, fine_temp, press_q8,
//                                        hum_q10; tuser: press_valid
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one item per cycle while the output register is empty or taken
// pressure goes through the 36-stage restoring divider (one bit per stage)
// rst clears all valid bits and the coefficient registers
// the whole pipeline advances when the output register is empty or taken
`default_nettype none
module pth_sensor_compensation_top
  import pthc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [55:0]    s_axis_tdata,   // adc_temp, adc_press, adc_hum
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [79:0]         m_axis_tdata,   // temp_centi, fine_temp, press_q8, hum_q10
  output logic                m_axis_tuser,   // press_valid
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [CIW-1:0] cfg_index,
  input  wire logic [63:0]    cfg_data
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [47:0] mixed_coeffs;
  logic [31:0] hum_coeffs;
  coeffs_t     c;
  logic        en;
  logic        f_valid;
  div_in_t     f_out;
  logic        d_valid;
  div_out_t    d_out;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      mixed_coeffs      <= '0;
      hum_coeffs        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMP:     temp_coeffs       <= cfg_data[47:0];
        CFG_PRESS_LO: press_coeffs_low  <= cfg_data;
        CFG_PRESS_HI: press_coeffs_high <= cfg_data;
        CFG_MIXED:    mixed_coeffs      <= cfg_data[47:0];
        CFG_HUM:      hum_coeffs        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    c.t1 = temp_coeffs[15:0];
    c.t2 = temp_coeffs[31:16];
    c.t3 = temp_coeffs[47:32];
    c.p1 = press_coeffs_low[15:0];
    c.p2 = press_coeffs_low[31:16];
    c.p3 = press_coeffs_low[47:32];
    c.p4 = press_coeffs_low[63:48];
    c.p5 = press_coeffs_high[15:0];
    c.p6 = press_coeffs_high[31:16];
    c.p7 = press_coeffs_high[47:32];
    c.p8 = press_coeffs_high[63:48];
    c.p9 = mixed_coeffs[15:0];
    c.h1 = mixed_coeffs[23:16];
    c.h2 = mixed_coeffs[39:24];
    c.h3 = mixed_coeffs[47:40];
    c.h4 = hum_coeffs[11:0];
    c.h5 = hum_coeffs[23:12];
    c.h6 = hum_coeffs[31:24];
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  pthc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .adc_temp  (s_axis_tdata[19:0]),
    .adc_press (s_axis_tdata[39:20]),
    .adc_hum   (s_axis_tdata[55:40]),
    .c         (c),
    .out_valid (f_valid),
    .out       (f_out)
  );

  pthc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in        (f_out),
    .out_valid (d_valid),
    .out       (d_out)
  );

  pthc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in        (d_out),
    .c         (c),
    .out_valid (m_axis_tvalid),
    .out       (res)
  );

  assign m_axis_tdata = {3'b000, res.hum, res.press, res.tf, res.temp};
  assign m_axis_tuser = res.pvalid;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pthc_pkg::*;

  localparam int  LATENCY   = 60;
  localparam int  CYCLE_CAP = 600000;
  localparam int  N_PHASES  = 8;
  localparam int  PHASE_LEN = 241;
  localparam logic [CIW-1:0] CFG_LAST_IDX = CIW'((1 << CIW) - 1);

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [55:0]     s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [79:0]     m_axis_tdata;
  logic            m_axis_tuser;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CIW-1:0]  cfg_index = '0;
  logic [63:0]     cfg_data = '0;

  pth_sensor_compensation_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the coefficient registers
  logic [63:0] temp_reg, plow_reg, phigh_reg, mixed_reg, hum_reg;
  res_t        sample_q[$];
  int          fails = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  typedef struct {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    int          setup;     // 0 reset values, 1 typical, 2 all ones
    bit          typed;
    res_t        want;
  } vec_t;

  vec_t vecs[$];
  logic [63:0] cal_sets[7][5];

  function automatic longint sfld(logic [63:0] r, int pos, int w);
    longint v;
    v = longint'((r >> pos) & ((64'd1 << w) - 64'd1));
    if (v[w-1]) v -= (64'sd1 <<< w);
    return v;
  endfunction

  function automatic longint ufld(logic [63:0] r, int pos, int w);
    return longint'((r >> pos) & ((64'd1 << w) - 64'd1));
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic void shadow_write(logic [CIW-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_TEMP:     temp_reg  = val & 64'hFFFF_FFFF_FFFF;
      CFG_PRESS_LO: plow_reg  = val;
      CFG_PRESS_HI: phigh_reg = val;
      CFG_MIXED:    mixed_reg = val & 64'hFFFF_FFFF_FFFF;
      CFG_HUM:      hum_reg   = val & 64'hFFFF_FFFF;
      default: ;
    endcase
  endfunction

  function automatic res_t compensate(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, num, tf, temp, press, v1, v2, u, uh, ul, lim, d, qd, rd, q, qs, c1, c2;
    longint hv, ha, hb, s, hum;
    res_t r;
    t1 = ufld(temp_reg, 0, 16);   t2 = sfld(temp_reg, 16, 16);  t3 = sfld(temp_reg, 32, 16);
    p1 = ufld(plow_reg, 0, 16);   p2 = sfld(plow_reg, 16, 16);  p3 = sfld(plow_reg, 32, 16);
    p4 = sfld(plow_reg, 48, 16);
    p5 = sfld(phigh_reg, 0, 16);  p6 = sfld(phigh_reg, 16, 16); p7 = sfld(phigh_reg, 32, 16);
    p8 = sfld(phigh_reg, 48, 16);
    p9 = sfld(mixed_reg, 0, 16);  h1 = ufld(mixed_reg, 16, 8);  h2 = sfld(mixed_reg, 24, 16);
    h3 = ufld(mixed_reg, 40, 8);
    h4 = sfld(hum_reg, 0, 12);    h5 = sfld(hum_reg, 12, 12);   h6 = sfld(hum_reg, 24, 8);

    a    = longint'(at) - 16 * t1;
    num  = a * t2 * 64'sd1048576 + a * a * t3;
    tf   = clip(num / (64'sd1 <<< 34), -524288, 524287);
    temp = clip((tf * 5 + 128) >>> 8, -4000, 8500);

    press = 0;
    r.pvalid = 1'b0;
    v1 = tf - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (64'sd1 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
    u  = (64'sd1 <<< 47) + v1;
    uh = u >>> 17;
    ul = u - uh * 131072;
    v1 = (uh * p1 + ((ul * p1) >>> 17)) >>> 16;
    if (v1 != 0) begin
      lim = 64'sd1 <<< 35;
      d   = (64'sd1048576 - longint'(ap)) * (64'sd1 <<< 31) - v2;
      qd  = d / v1;
      rd  = d % v1;
      // quotient clamped before the nonlinear correction
      if (qd >= (64'sd1 <<< 24)) q = lim;
      else if (qd <= -(64'sd1 <<< 24)) q = -lim;
      else q = clip(qd * 3125 + (rd * 3125) / v1, -lim, lim);
      qs = q >>> 13;
      c1 = (p9 * qs * qs) >>> 25;
      c2 = (p8 * q) >>> 19;
      press = clip(((q + c1 + c2) >>> 8) + p7 * 16, 0, 33554431);
      r.pvalid = 1'b1;
    end

    hv = tf - 76800;
    ha = (longint'(ah) * 16384 - h4 * 1048576 - h5 * hv + 16384) >>> 15;
    hb = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32768);
    hb = ((((hb >>> 10) + 2097152) * h2) + 8192) >>> 14;
    hv = ha * hb;
    s  = hv >>> 15;
    hv -= (((s * s) >>> 7) * h1) >>> 4;
    hv  = clip(hv, 0, 419430400);
    hum = hv >>> 12;

    r.temp  = temp[TCW-1:0];
    r.tf    = tf[TFW-1:0];
    r.press = press[PW-1:0];
    r.hum   = hum[HW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    res_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        w = sample_q.pop_front();
        if (m_axis_tdata[14:0] !== w.temp) begin
          $error("temp_centi: expected %0d actual %0d", w.temp, $signed(m_axis_tdata[14:0]));
          fails++;
        end
        if (m_axis_tdata[34:15] !== w.tf) begin
          $error("fine_temp: expected %0d actual %0d", w.tf, $signed(m_axis_tdata[34:15]));
          fails++;
        end
        if (m_axis_tdata[59:35] !== w.press) begin
          $error("press_q8: expected %0d actual %0d", w.press, m_axis_tdata[59:35]);
          fails++;
        end
        if (m_axis_tuser !== w.pvalid) begin
          $error("press_valid: expected %0d actual %0d", w.pvalid, m_axis_tuser);
          fails++;
        end
        if (m_axis_tdata[76:60] !== w.hum) begin
          $error("hum_q10: expected %0d actual %0d", w.hum, m_axis_tdata[76:60]);
          fails++;
        end
      end
    end
  end

  task automatic send_sample(logic [19:0] at, logic [19:0] ap, logic [15:0] ah,
                             bit typed, res_t want);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ah, ap, at};
    sample_q.push_back(typed ? want : compensate(at, ap, ah));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    shadow_write(idx, val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cal(int set, bit junk);
    drain();
    write_reg(CFG_TEMP,     cal_sets[set][0]);
    write_reg(CFG_PRESS_LO, cal_sets[set][1]);
    write_reg(CFG_PRESS_HI, cal_sets[set][2]);
    write_reg(CFG_MIXED,    cal_sets[set][3]);
    write_reg(CFG_HUM,      cal_sets[set][4]);
    // writes past the last register must be dropped
    if (junk)
      for (int k = CFG_HUM + 1; k <= CFG_LAST_IDX; k++)
        write_reg(CIW'(k), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [19:0] at, ap;
    logic [15:0] ah;
    int          cur_setup;
    res_t        zero_res;

    temp_reg = '0; plow_reg = '0; phigh_reg = '0; mixed_reg = '0; hum_reg = '0;
    zero_res = '0;

    // typical part calibration
    cal_sets[0] = '{64'h0000_FC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                    64'hC6F8_3C8C_FFF9_008C, 64'h0000_0001_6A4B_1770, 64'h0000_0000_1E03_2139};
    cal_sets[1] = '{'1, '1, '1, '1, '1};
    cal_sets[2] = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h7F7F_F7FF_7FF7_7FF7};
    cal_sets[3] = '{64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                    64'h8000_8000_8000_8000, 64'h0080_8008_0080_0800};
    cal_sets[4] = '{'0, '0, '0, '0, '0};
    for (int s = 5; s < 7; s++)
      for (int k = 0; k < 5; k++)
        cal_sets[s][k] = {$urandom, $urandom};
    // near-typical set with perturbed low bits
    for (int k = 0; k < 5; k++)
      cal_sets[6][k] = cal_sets[0][k] ^ {32'h0, 24'h0, 8'($urandom)};

    for (int su = 0; su < 3; su++) begin
      vecs.push_back('{20'h00000, 20'h00000, 16'h0000, su, su == 0, zero_res});
      vecs.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, su, su == 0, zero_res});
      vecs.push_back('{20'hFFFFF, 20'h00000, 16'h0000, su, su == 0, zero_res});
      vecs.push_back('{20'h00000, 20'hFFFFF, 16'hFFFF, su, su == 0, zero_res});
      vecs.push_back('{20'd519888, 20'd415148, 16'd27000, su, su == 0, zero_res});
      vecs.push_back('{20'hAAAAA, 20'h55555, 16'hA5A5, su, su == 0, zero_res});
      vecs.push_back('{20'h55555, 20'hAAAAA, 16'h5A5A, su, su == 0, zero_res});
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_setup = 0;
    foreach (vecs[i]) begin
      if (vecs[i].setup != cur_setup) begin
        cur_setup = vecs[i].setup;
        load_cal(cur_setup - 1, 1'b0);
      end
      send_sample(vecs[i].adc_t, vecs[i].adc_p, vecs[i].adc_h, vecs[i].typed, vecs[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct  = 0;
      stall_pct = 0;
      load_cal(ph % 7, ph == 4 || ph == 7);
      case (ph % 4)
        1: idle_pct = 56;
        2: stall_pct = 56;
        3: begin idle_pct = 21; stall_pct = 21; end
        default: ;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // one hold-off until the pipeline is empty
        if (ph == 2 && n == PHASE_LEN / 2) begin
          s_axis_tvalid <= 1'b0;
          while (sample_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 70) begin
          at = 20'($urandom_range(600000, 400000));
          ap = 20'($urandom_range(500000, 200000));
          ah = 16'($urandom_range(40000, 20000));
        end else begin
          at = 20'($urandom);
          ap = 20'($urandom);
          ah = 16'($urandom);
        end
        send_sample(at, ap, ah, 1'b0, zero_res);
        if (n % 60 == 59) begin
          // alternate stretches with no idling and no stalling
          idle_pct  = (idle_pct == 0 && ph % 4 != 0) ? ((ph % 4 == 3) ? 21 : 56) : 0;
          stall_pct = (stall_pct == 0 && ph % 4 >= 2) ? ((ph % 4 == 3) ? 21 : 56) : 0;
          if (ph % 4 == 1) stall_pct = 0;
          if (ph % 4 == 2) idle_pct = 0;
        end
      end
    end

    stall_pct = 0;
    drain();
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
